### rtl/core/cdu_pkg.sv
// Package for the calendar date unit: constants, pipeline stage types and
// the small calendar tables used by the stage modules. No dependencies.
`timescale 1ns / 1ps

package cdu_pkg;

	localparam logic [13:0] FIRST_YEAR  = 14'd1700;
	localparam logic [13:0] LAST_YEAR   = 14'd9999;
	localparam logic [3:0]  FIRST_MONTH = 4'd3;
	localparam logic [3:0]  FEBRUARY    = 4'd2;
	localparam logic [3:0]  DECEMBER    = 4'd12;
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [21:0] BASE_DAYS   = 22'd620912;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [26:0] yprod;
		logic        yr_ok;
		logic        mo_ok;
		logic        dy_ok;
		logic        early;
	} s1_t;

	typedef struct packed {
		logic        was_valid;
		logic [13:0] eff_year;
		logic [3:0]  eff_month;
		logic [4:0]  eff_day;
		logic [2:0]  quarter;
		logic        leap;
		logic [8:0]  day_of_year;
		logic [13:0] next_year;
		logic [3:0]  next_month;
		logic [4:0]  next_day;
		logic        at_last_date;
	} info_t;

	typedef struct packed {
		info_t       info;
		logic [13:0] yy;
		logic [26:0] yyprod;
		logic [8:0]  doym;
	} s2_t;

	typedef struct packed {
		info_t       info;
		logic [21:0] days;
	} s3_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = lp ? 5'd29 : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// Days from March 1 to the first of the month, in a year that starts in March.
	function automatic logic [8:0] march_offset(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd3:    n = 9'd0;
			4'd4:    n = 9'd31;
			4'd5:    n = 9'd61;
			4'd6:    n = 9'd92;
			4'd7:    n = 9'd122;
			4'd8:    n = 9'd153;
			4'd9:    n = 9'd184;
			4'd10:   n = 9'd214;
			4'd11:   n = 9'd245;
			4'd12:   n = 9'd275;
			4'd1:    n = 9'd306;
			4'd2:    n = 9'd337;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] quarter_of(input logic [3:0] m);
		logic [2:0] q;
		case (m)
			4'd1, 4'd2, 4'd3:    q = 3'd1;
			4'd4, 4'd5, 4'd6:    q = 3'd2;
			4'd7, 4'd8, 4'd9:    q = 3'd3;
			4'd10, 4'd11, 4'd12: q = 3'd4;
			default:             q = 3'd0;
		endcase
		return q;
	endfunction

endpackage

### rtl/core/cdu_in_if.sv
// Input channel of the calendar date unit: valid/ready handshake and one date word.
// Depends on nothing.
`timescale 1ns / 1ps

interface cdu_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] year;
	logic [6:0]  month;
	logic [6:0]  day;

	modport source (output valid, output year, output month, output day, input ready);
	modport sink (input valid, input year, input month, input day, output ready);
endinterface

### rtl/core/cdu_out_if.sv
// Output channel of the calendar date unit: valid/ready handshake and one result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface cdu_out_if;
	logic        valid;
	logic        ready;
	logic        was_valid;
	logic [13:0] eff_year;
	logic [3:0]  eff_month;
	logic [4:0]  eff_day;
	logic [2:0]  quarter;
	logic        leap;
	logic [8:0]  day_of_year;
	logic [2:0]  weekday_num;
	logic [13:0] next_year;
	logic [3:0]  next_month;
	logic [4:0]  next_day;
	logic        at_last_date;

	modport source (output valid, output was_valid, output eff_year, output eff_month,
		output eff_day, output quarter, output leap, output day_of_year,
		output weekday_num, output next_year, output next_month, output next_day,
		output at_last_date, input ready);
	modport sink (input valid, input was_valid, input eff_year, input eff_month,
		input eff_day, input quarter, input leap, input day_of_year,
		input weekday_num, input next_year, input next_month, input next_day,
		input at_last_date, output ready);
endinterface

### rtl/core/cdu_front.sv
// Stage one: range checks on the raw date and the year's quotient product by 100.
// Depends on cdu_pkg and cdu_in_if.
`timescale 1ns / 1ps

module cdu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	cdu_in_if.sink          din,
	output logic            vld_s1,
	output cdu_pkg::s1_t    data_s1
);

	cdu_pkg::s1_t nxt;

	assign din.ready = adv;

	always_comb begin
		nxt.year  = din.year;
		nxt.month = din.month;
		nxt.day   = din.day;
		nxt.yprod = 27'(din.year) * 27'(cdu_pkg::RECIP_100);
		nxt.yr_ok = (din.year >= cdu_pkg::FIRST_YEAR) && (din.year <= cdu_pkg::LAST_YEAR);
		nxt.mo_ok = (din.month >= 7'd1) && (din.month <= 7'(cdu_pkg::DECEMBER));
		nxt.dy_ok = (din.day != 7'd0);
		nxt.early = (din.year == cdu_pkg::FIRST_YEAR) && (din.month < 7'(cdu_pkg::FIRST_MONTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

endmodule

### rtl/core/cdu_date.sv
// Stage two: leap rule, validity, effective date, day of year, next date and the March-based year terms.
// Depends on cdu_pkg.
`timescale 1ns / 1ps

module cdu_date (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_s1,
	input  cdu_pkg::s1_t    data_s1,
	output logic            vld_s2,
	output cdu_pkg::s2_t    data_s2
);

	cdu_pkg::s2_t nxt;
	logic [6:0]   cent;
	logic [13:0]  rem;
	logic         leap_raw;
	logic [4:0]   len_raw;
	logic         ok;
	logic [13:0]  ey;
	logic [3:0]   em;
	logic [4:0]   ed;
	logic         lp;
	logic [4:0]   elen;

	always_comb begin
		cent     = data_s1.yprod[25:cdu_pkg::RECIP_SHIFT];
		rem      = data_s1.year - 14'(cent) * 14'd100;
		leap_raw = (data_s1.year[1:0] == 2'd0) && ((rem != 14'd0) || (cent[1:0] == 2'd0));
		len_raw  = cdu_pkg::month_len(data_s1.month[3:0], leap_raw);
		ok       = data_s1.yr_ok && data_s1.mo_ok && data_s1.dy_ok && !data_s1.early
			&& (data_s1.day <= 7'(len_raw));

		ey   = ok ? data_s1.year : cdu_pkg::FIRST_YEAR;
		em   = ok ? data_s1.month[3:0] : cdu_pkg::FIRST_MONTH;
		ed   = ok ? data_s1.day[4:0] : 5'd1;
		lp   = ok && leap_raw;
		elen = cdu_pkg::month_len(em, lp);

		nxt.info.was_valid   = ok;
		nxt.info.eff_year    = ey;
		nxt.info.eff_month   = em;
		nxt.info.eff_day     = ed;
		nxt.info.quarter     = cdu_pkg::quarter_of(em);
		nxt.info.leap        = lp;
		nxt.info.day_of_year = cdu_pkg::days_before(em) + 9'(ed)
			+ 9'(lp && (em > cdu_pkg::FEBRUARY));

		nxt.info.at_last_date = 1'b0;
		if (ed < elen) begin
			nxt.info.next_year  = ey;
			nxt.info.next_month = em;
			nxt.info.next_day   = ed + 5'd1;
		end else if (em < cdu_pkg::DECEMBER) begin
			nxt.info.next_year  = ey;
			nxt.info.next_month = em + 4'd1;
			nxt.info.next_day   = 5'd1;
		end else if (ey < cdu_pkg::LAST_YEAR) begin
			nxt.info.next_year  = ey + 14'd1;
			nxt.info.next_month = 4'd1;
			nxt.info.next_day   = 5'd1;
		end else begin
			nxt.info.next_year    = ey;
			nxt.info.next_month   = em;
			nxt.info.next_day     = ed;
			nxt.info.at_last_date = 1'b1;
		end

		// January and February belong to the previous March-based year.
		nxt.yy     = ey - 14'(em <= cdu_pkg::FEBRUARY);
		nxt.yyprod = 27'(nxt.yy) * 27'(cdu_pkg::RECIP_100);
		nxt.doym   = cdu_pkg::march_offset(em) + 9'(ed) - 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= nxt;
		end
	end

endmodule

### rtl/core/cdu_weekday.sv
// Stages three and four: day count since 1700-03-01, its remainder by seven,
// and the output register. Depends on cdu_pkg and cdu_out_if.
`timescale 1ns / 1ps

module cdu_weekday (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_s2,
	input  cdu_pkg::s2_t    data_s2,
	cdu_out_if.source       dout
);

	cdu_pkg::s3_t  nxt3;
	cdu_pkg::s3_t  data_s3;
	logic          vld_s3;
	logic [6:0]    cc;
	logic [22:0]   total;
	logic [23:0]   pad;
	logic [5:0]    fold1;
	logic [3:0]    fold2;
	logic [2:0]    rem7;
	cdu_pkg::info_t info_s4;
	logic [2:0]    wd_s4;
	logic          vld_s4;

	always_comb begin
		cc    = data_s2.yyprod[25:cdu_pkg::RECIP_SHIFT];
		total = 23'(data_s2.yy) * 23'd365 + 23'(data_s2.yy[13:2]) + 23'(cc[6:2])
			+ 23'(data_s2.doym) - 23'(cc) - 23'(cdu_pkg::BASE_DAYS);
		nxt3.info = data_s2.info;
		nxt3.days = total[21:0];
	end

	// Eight is one more than seven, so three-bit digits sum to the same remainder.
	always_comb begin
		pad   = {2'b00, data_s3.days};
		fold1 = 6'd0;
		for (int i = 0; i < 8; i++) begin
			fold1 = fold1 + 6'(pad[3*i +: 3]);
		end
		fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
		if (fold2 >= 4'd14) begin
			rem7 = 3'd0;
		end else if (fold2 >= 4'd7) begin
			rem7 = 3'(fold2 - 4'd7);
		end else begin
			rem7 = fold2[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s3 <= nxt3;
			info_s4 <= data_s3.info;
			wd_s4   <= rem7 + 3'd1;
		end
	end

	assign dout.valid        = vld_s4;
	assign dout.was_valid    = info_s4.was_valid;
	assign dout.eff_year     = info_s4.eff_year;
	assign dout.eff_month    = info_s4.eff_month;
	assign dout.eff_day      = info_s4.eff_day;
	assign dout.quarter      = info_s4.quarter;
	assign dout.leap         = info_s4.leap;
	assign dout.day_of_year  = info_s4.day_of_year;
	assign dout.weekday_num  = wd_s4;
	assign dout.next_year    = info_s4.next_year;
	assign dout.next_month   = info_s4.next_month;
	assign dout.next_day     = info_s4.next_day;
	assign dout.at_last_date = info_s4.at_last_date;

endmodule

### rtl/core/calendar_date_unit.sv
// Top level of the calendar date unit: four-stage pipeline from a date word to
// its calendar result word. Depends on cdu_pkg, cdu_in_if, cdu_out_if and the stage modules.
//
//   channel | dir | handshake     | word
//   din     | in  | valid / ready | year, month, day
//   dout    | out | valid / ready | was_valid .. at_last_date
//
// A word passes the stage registers s1 to s4 on its way to dout; one word can enter
// every cycle while dout does not stall. The pipeline moves as one: every stage
// advances when the output register is empty or its word is taken, so a stall on
// dout holds all stages and din.ready falls. Reset clears only the stage valid bits.
`timescale 1ns / 1ps

module calendar_date_unit (
	input  logic        clk,
	input  logic        arst_n,
	cdu_in_if.sink      din,
	cdu_out_if.source   dout
);

	logic         adv;
	logic         vld_s1;
	logic         vld_s2;
	cdu_pkg::s1_t data_s1;
	cdu_pkg::s2_t data_s2;

	assign adv = !dout.valid || dout.ready;

	cdu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.din     (din),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1)
	);

	cdu_date u_date (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1),
		.vld_s2  (vld_s2),
		.data_s2 (data_s2)
	);

	cdu_weekday u_weekday (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s2  (vld_s2),
		.data_s2 (data_s2),
		.dout    (dout)
	);

endmodule

### verif/tb_calendar_date_unit.sv
// Self-checking testbench for calendar_date_unit: directed and random dates, each result
// word checked against a set word or a calendar predictor under random source bursts and sink stalls.
// Depends on cdu_pkg, cdu_in_if, cdu_out_if and the calendar_date_unit RTL.
`timescale 1ns / 1ps

module tb_calendar_date_unit;

	localparam int RANDOM_DATES = 1750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic        was_valid;
		logic [13:0] eff_year;
		logic [3:0]  eff_month;
		logic [4:0]  eff_day;
		logic [2:0]  quarter;
		logic        leap;
		logic [8:0]  day_of_year;
		logic [2:0]  weekday_num;
		logic [13:0] next_year;
		logic [3:0]  next_month;
		logic [4:0]  next_day;
		logic        at_last_date;
	} cal_word_t;

	typedef struct {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		bit          typed;
		cal_word_t   word;
	} date_row_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_MOSTLY} sink_mode_t;

	localparam cal_word_t REPLACED_WORD = '{1'b0, 14'd1700, 4'd3, 5'd1, 3'd1, 1'b0,
		9'd60, 3'd1, 14'd1700, 4'd3, 5'd2, 1'b0};
	localparam cal_word_t FIRST_WORD = '{1'b1, 14'd1700, 4'd3, 5'd1, 3'd1, 1'b0,
		9'd60, 3'd1, 14'd1700, 4'd3, 5'd2, 1'b0};
	localparam cal_word_t LAST_WORD = '{1'b1, 14'd9999, 4'd12, 5'd31, 3'd4, 1'b0,
		9'd365, 3'd5, 14'd9999, 4'd12, 5'd31, 1'b1};

	logic clk;
	logic arst_n;
	logic sink_ready = 1'b0;
	int   mismatch_count = 0;
	int   result_count = 0;
	int   cycle_count = 0;
	int   burst_left = 0;
	int   sink_left = 0;
	int   sink_phase = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	cal_word_t  pending_words[$];
	date_row_t  directed_rows[$];

	cdu_in_if  din_ch();
	cdu_out_if dout_ch();

	assign dout_ch.ready = sink_ready;

	calendar_date_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Day count with years that start in March, so February ends each year.
	function automatic int unsigned march_day_count(input int unsigned y, input int unsigned m,
		input int unsigned d);
		int unsigned yy;
		int unsigned mm;
		yy = (m <= 2) ? y - 1 : y;
		mm = (m + 9) % 12;
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
	endfunction

	function automatic cal_word_t calendar_result(input int unsigned y_in,
		input int unsigned m_in, input int unsigned d_in);
		cal_word_t   w;
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned len;
		int unsigned doy;
		int unsigned k;
		bit          ok;
		bit          lp;
		y = y_in;
		m = m_in;
		d = d_in;
		ok = (y >= 32'(cdu_pkg::FIRST_YEAR)) && (y <= 32'(cdu_pkg::LAST_YEAR)) && (m >= 1) &&
			(m <= 32'(cdu_pkg::DECEMBER)) && (d >= 1) && (d <= month_days(y, m)) &&
			!((y == 32'(cdu_pkg::FIRST_YEAR)) && (m < 32'(cdu_pkg::FIRST_MONTH)));
		if (!ok) begin
			y = 32'(cdu_pkg::FIRST_YEAR);
			m = 32'(cdu_pkg::FIRST_MONTH);
			d = 1;
		end
		lp = leap_year(y);
		len = month_days(y, m);
		doy = d + ((lp && m > 32'(cdu_pkg::FEBRUARY)) ? 1 : 0);
		for (k = 1; k < m; k++)
			doy += month_days(1, k);
		w.was_valid = ok;
		w.eff_year = 14'(y);
		w.eff_month = 4'(m);
		w.eff_day = 5'(d);
		w.quarter = 3'((m + 2) / 3);
		w.leap = lp;
		w.day_of_year = 9'(doy);
		w.weekday_num = 3'((march_day_count(y, m, d) - march_day_count(
			32'(cdu_pkg::FIRST_YEAR), 32'(cdu_pkg::FIRST_MONTH), 1)) % 7 + 1);
		w.at_last_date = 1'b0;
		if (d < len) begin
			w.next_year = 14'(y);
			w.next_month = 4'(m);
			w.next_day = 5'(d + 1);
		end else if (m < 32'(cdu_pkg::DECEMBER)) begin
			w.next_year = 14'(y);
			w.next_month = 4'(m + 1);
			w.next_day = 5'd1;
		end else if (y < 32'(cdu_pkg::LAST_YEAR)) begin
			w.next_year = 14'(y + 1);
			w.next_month = 4'd1;
			w.next_day = 5'd1;
		end else begin
			w.next_year = 14'(y);
			w.next_month = 4'(m);
			w.next_day = 5'(d);
			w.at_last_date = 1'b1;
		end
		return w;
	endfunction

	function automatic logic [13:0] pick_year();
		case ($urandom_range(0, 5))
			0:       return 14'($urandom_range(17, 99) * 100);
			1:       return 14'($urandom_range(1700, 1710));
			2:       return 14'($urandom_range(9990, 9999));
			default: return 14'($urandom_range(1700, 9999));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("tb: mismatch at result %0d: %s", result_count, what);
	endtask

	task automatic add_row(input int unsigned y, input int unsigned m, input int unsigned d,
		input bit typed, input cal_word_t word);
		date_row_t row;
		row.year = 14'(y);
		row.month = 7'(m);
		row.day = 7'(d);
		row.typed = typed;
		row.word = word;
		directed_rows.push_back(row);
	endtask

	// Called at a rising edge; returns at the edge where the date word is taken.
	task automatic send_date(input logic [13:0] y, input logic [6:0] m, input logic [6:0] d,
		input cal_word_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
			if ($urandom_range(0, 5) == 0) begin
				burst_left = 200;
				gap = 0;
			end
			if (gap != 0) begin
				din_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		din_ch.valid <= 1'b1;
		din_ch.year <= y;
		din_ch.month <= m;
		din_ch.day <= d;
		do @(posedge clk); while (din_ch.ready !== 1'b1);
		pending_words.push_back(want);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		cal_word_t got;
		cal_word_t want;
		if (arst_n && dout_ch.valid === 1'b1 && sink_ready) begin
			got = '{dout_ch.was_valid, dout_ch.eff_year, dout_ch.eff_month, dout_ch.eff_day,
				dout_ch.quarter, dout_ch.leap, dout_ch.day_of_year, dout_ch.weekday_num,
				dout_ch.next_year, dout_ch.next_month, dout_ch.next_day, dout_ch.at_last_date};
			if (pending_words.size() == 0) begin
				report_mismatch("result word with no date pending");
			end else begin
				want = pending_words.pop_front();
				if (got.was_valid !== want.was_valid)
					report_mismatch($sformatf("was_valid %0d, want %0d", got.was_valid,
						want.was_valid));
				if (got.eff_year !== want.eff_year)
					report_mismatch($sformatf("eff_year %0d, want %0d", got.eff_year,
						want.eff_year));
				if (got.eff_month !== want.eff_month)
					report_mismatch($sformatf("eff_month %0d, want %0d", got.eff_month,
						want.eff_month));
				if (got.eff_day !== want.eff_day)
					report_mismatch($sformatf("eff_day %0d, want %0d", got.eff_day,
						want.eff_day));
				if (got.quarter !== want.quarter)
					report_mismatch($sformatf("quarter %0d, want %0d", got.quarter,
						want.quarter));
				if (got.leap !== want.leap)
					report_mismatch($sformatf("leap %0d, want %0d", got.leap, want.leap));
				if (got.day_of_year !== want.day_of_year)
					report_mismatch($sformatf("day_of_year %0d, want %0d", got.day_of_year,
						want.day_of_year));
				if (got.weekday_num !== want.weekday_num)
					report_mismatch($sformatf("weekday_num %0d, want %0d", got.weekday_num,
						want.weekday_num));
				if (got.next_year !== want.next_year)
					report_mismatch($sformatf("next_year %0d, want %0d", got.next_year,
						want.next_year));
				if (got.next_month !== want.next_month)
					report_mismatch($sformatf("next_month %0d, want %0d", got.next_month,
						want.next_month));
				if (got.next_day !== want.next_day)
					report_mismatch($sformatf("next_day %0d, want %0d", got.next_day,
						want.next_day));
				if (got.at_last_date !== want.at_last_date)
					report_mismatch($sformatf("at_last_date %0d, want %0d", got.at_last_date,
						want.at_last_date));
			end
			result_count++;
		end
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(16, 96);
		end
		sink_left--;
		sink_phase++;
		case (sink_mode)
			SINK_OPEN:   sink_ready <= 1'b1;
			SINK_COIN:   sink_ready <= 1'($urandom_range(0, 1));
			SINK_THIRD:  sink_ready <= (sink_phase % 3 == 0);
			SINK_MOSTLY: sink_ready <= ($urandom_range(0, 7) != 0);
			default:     sink_ready <= 1'b1;
		endcase
	end

	initial begin
		int          i;
		int          kind;
		int unsigned len;
		logic [13:0] y;
		logic [6:0]  m;
		logic [6:0]  d;
		arst_n = 1'b0;
		din_ch.valid = 1'b0;
		din_ch.year = '0;
		din_ch.month = '0;
		din_ch.day = '0;

		add_row(0, 0, 0, 1, REPLACED_WORD);
		add_row(16383, 127, 127, 1, REPLACED_WORD);
		add_row(1699, 12, 31, 1, REPLACED_WORD);
		add_row(1700, 1, 1, 1, REPLACED_WORD);
		add_row(1700, 2, 28, 1, REPLACED_WORD);
		add_row(10000, 1, 1, 1, REPLACED_WORD);
		add_row(2000, 0, 1, 1, REPLACED_WORD);
		add_row(2000, 13, 1, 1, REPLACED_WORD);
		add_row(2000, 1, 0, 1, REPLACED_WORD);
		add_row(2001, 2, 29, 1, REPLACED_WORD);
		add_row(1900, 2, 29, 1, REPLACED_WORD);
		add_row(2023, 4, 31, 1, REPLACED_WORD);
		add_row(2024, 1, 32, 1, REPLACED_WORD);
		add_row(1700, 3, 1, 1, FIRST_WORD);
		add_row(9999, 12, 31, 1, LAST_WORD);
		add_row(2000, 2, 29, 0, '0);
		add_row(2024, 2, 29, 0, '0);
		add_row(2023, 12, 31, 0, '0);
		add_row(9999, 12, 30, 0, '0);
		add_row(1700, 12, 31, 0, '0);
		add_row(2100, 2, 28, 0, '0);
		add_row(2400, 2, 29, 0, '0);
		add_row(1701, 1, 1, 0, '0);
		add_row(1999, 6, 30, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_date(directed_rows[r].year, directed_rows[r].month, directed_rows[r].day,
				directed_rows[r].typed ? directed_rows[r].word :
				calendar_result(32'(directed_rows[r].year), 32'(directed_rows[r].month),
				32'(directed_rows[r].day)));

		// Most dates are well formed; the rest probe the limits and raw bit patterns.
		for (i = 0; i < RANDOM_DATES; i++) begin
			kind = $urandom_range(0, 9);
			y = pick_year();
			m = 7'($urandom_range(1, 12));
			len = month_days(32'(y), 32'(m));
			d = 7'd1;
			case (kind)
				0, 1, 2, 3, 4, 5: d = 7'(($urandom_range(0, 2) == 0) ? len :
					$urandom_range(1, len));
				6:                d = 7'(len + 1);
				7:                {y, m, d} = 28'($urandom);
				8: begin
					case ($urandom_range(0, 5))
						0:       y = 14'd1699;
						1:       y = 14'd1700;
						2:       y = 14'd1900;
						3:       y = 14'd2000;
						4:       y = 14'd9999;
						default: y = 14'd10000;
					endcase
					d = 7'($urandom_range(0, 32));
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						m = 7'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 127));
					else
						d = 7'd0;
				end
			endcase
			send_date(y, m, d, calendar_result(32'(y), 32'(m), 32'(d)));
		end

		din_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
